// ===== hw/rtl/clk_pram_pkg.sv =====
// Package: shared types and constants for the clock and parameter RAM block.
`default_nettype none
package clk_pram_pkg;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_ACCESS = 3'b100
  } state_t;

  // Configuration register indexes.
  localparam logic CFG_ROM_IS_32BIT     = 1'b0;
  localparam logic CFG_ADDRESSING_24BIT = 1'b1;

  // Command decode.
  localparam logic [3:0] EXT_SELECT = 4'b0111;

  // Extended store entries with fixed behavior.
  localparam logic [7:0] ADDR_ROM_FLAGS = 8'h08;
  localparam logic [7:0] ADDR_FORCED    = 8'h8a;
  localparam logic [7:0] ADDR_NET_0     = 8'he0;
  localparam logic [7:0] ADDR_NET_1     = 8'he1;
  localparam logic [7:0] ADDR_NET_2     = 8'he2;
  localparam logic [7:0] ADDR_NET_3     = 8'he3;

  localparam logic [7:0] ROM_FLAGS_MASK = 8'hf8;
  localparam logic [7:0] FORCED_BITS    = 8'h05;

  // Default bytes returned for entries 0xe0..0xe3 when no network setup is stored.
  localparam logic [7:0] NET_DEFAULT_0 = 8'h00;
  localparam logic [7:0] NET_DEFAULT_1 = 8'hf1;
  localparam logic [7:0] NET_DEFAULT_2 = 8'h00;
  localparam logic [7:0] NET_DEFAULT_3 = 8'h0a;

endpackage
`default_nettype wire

// ===== hw/rtl/clock_pram_register_access.sv =====
// Top level: clock and parameter RAM register access with a 256-byte store.
// An accepted transfer starts the store read; its result loads at the access commit.
// A new item is taken only after that commit, since the store is read, then written.
// The output register holds a finished result while the next item is taken.
// Reset (rst, synchronous): a clearing pass zeroes the store, item_ready low.
// Config writes are taken during the clearing pass as at any other time.
`default_nettype none
module clock_pram_register_access (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  // input items
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [14:0] command,
  input  wire logic [7:0]  write_byte,
  input  wire logic [31:0] clock_seconds,
  // result items
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [7:0]       result_byte
);

  clk_pram_pkg::state_t state, state_next;

  // Configuration registers.
  logic rom_is_32bit;
  logic addressing_24bit;

  // Parameter store: one synchronous RAM, registered read data.
  logic [7:0] param_store [256];
  logic [7:0] rd_data;
  logic       mem_re;
  logic       mem_we;
  logic [7:0] mem_waddr;
  logic [7:0] mem_wdata;

  // Clearing pass counter.
  logic [7:0] clr_addr;

  // Shadow copies of entries 0xe0 and 0xe1, so the network-default check
  // needs no second read port.
  logic [7:0] net_0;
  logic [7:0] net_1;

  // Fields of the item in flight.
  logic [7:2]  cmd_hold;
  logic [7:0]  data_hold;
  logic [7:0]  clk_byte_hold;
  logic [7:0]  addr_hold;

  // Decode of the incoming command, used to start the store read.
  logic       in_ext;
  logic [7:0] in_addr;
  logic [7:0] in_clk_byte;

  // Decode of the held command.
  logic       ext;
  logic       rd;
  logic [4:0] short_addr;
  logic       short_hit;
  logic       no_net;

  logic       accept;
  logic       commit;
  logic [7:0] res;
  logic       acc_we;
  logic [7:0] acc_wdata;

  assign item_ready = (state == clk_pram_pkg::ST_IDLE);
  assign accept     = item_valid && item_ready;
  // Finish the access once the output register is free or being drained.
  assign commit     = (state == clk_pram_pkg::ST_ACCESS) && (!result_valid || result_ready);

  // Extended accesses use {cmd[2:0], cmd[14:10]}; others the 5-bit cmd[6:2].
  assign in_ext  = (command[6:3] == clk_pram_pkg::EXT_SELECT);
  assign in_addr = in_ext ? {command[2:0], command[14:10]} : {3'b000, command[6:2]};

  always_comb begin
    case (command[3:2])
      2'd0:    in_clk_byte = clock_seconds[7:0];
      2'd1:    in_clk_byte = clock_seconds[15:8];
      2'd2:    in_clk_byte = clock_seconds[23:16];
      2'd3:    in_clk_byte = clock_seconds[31:24];
      default: in_clk_byte = clock_seconds[7:0];
    endcase
  end

  // Controller.
  always_comb begin
    state_next = state;
    case (state)
      clk_pram_pkg::ST_CLEAR: begin
        if (clr_addr == 8'hff) state_next = clk_pram_pkg::ST_IDLE;
      end
      clk_pram_pkg::ST_IDLE: begin
        if (accept) state_next = clk_pram_pkg::ST_ACCESS;
      end
      clk_pram_pkg::ST_ACCESS: begin
        if (commit) state_next = clk_pram_pkg::ST_IDLE;
      end
      default: state_next = clk_pram_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= clk_pram_pkg::ST_CLEAR;
      clr_addr <= 8'h00;
    end else begin
      state <= state_next;
      if (state == clk_pram_pkg::ST_CLEAR) clr_addr <= clr_addr + 8'h01;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_is_32bit     <= 1'b1;
      addressing_24bit <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        clk_pram_pkg::CFG_ROM_IS_32BIT:     rom_is_32bit     <= cfg_data;
        clk_pram_pkg::CFG_ADDRESSING_24BIT: addressing_24bit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the item's fields for the access.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_hold      <= command[7:2];
      data_hold     <= write_byte;
      clk_byte_hold <= in_clk_byte;
      addr_hold     <= in_addr;
    end
  end

  // Held command decode.
  assign ext        = (cmd_hold[6:3] == clk_pram_pkg::EXT_SELECT);
  assign rd         = cmd_hold[7];
  assign short_addr = cmd_hold[6:2];
  // Short addresses 0x08..0x0b and 0x10..0x1f reach the store.
  assign short_hit  = short_addr[4] || (short_addr[4:2] == 3'b010);
  assign no_net     = (net_0 == 8'h00) && (net_1 == 8'h00);

  // Result and write-back for the access.
  always_comb begin
    res       = data_hold;
    acc_we    = 1'b0;
    acc_wdata = data_hold;
    if (ext) begin
      if (rd) begin
        res = rd_data;
        if (addr_hold == clk_pram_pkg::ADDR_ROM_FLAGS) begin
          if (!rom_is_32bit) res = rd_data & clk_pram_pkg::ROM_FLAGS_MASK;
        end else if (addr_hold == clk_pram_pkg::ADDR_FORCED) begin
          res = rd_data | clk_pram_pkg::FORCED_BITS;
        end else if (no_net && (addr_hold[7:2] == clk_pram_pkg::ADDR_NET_0[7:2])) begin
          case (addr_hold[1:0])
            2'd0:    res = clk_pram_pkg::NET_DEFAULT_0;
            2'd1:    res = clk_pram_pkg::NET_DEFAULT_1;
            2'd2:    res = clk_pram_pkg::NET_DEFAULT_2;
            2'd3:    res = clk_pram_pkg::NET_DEFAULT_3;
            default: res = clk_pram_pkg::NET_DEFAULT_0;
          endcase
        end
      end else begin
        // Force the low bits of entry 0x8a unless 24-bit addressing is on.
        if ((addr_hold == clk_pram_pkg::ADDR_FORCED) && !addressing_24bit) begin
          acc_wdata = data_hold | clk_pram_pkg::FORCED_BITS;
        end
        res    = acc_wdata;
        acc_we = 1'b1;
      end
    end else if (short_hit) begin
      if (rd) res = rd_data;
      else    acc_we = 1'b1;
    end else if (!short_addr[4] && !short_addr[3] && rd) begin
      // Clock byte read.
      res = clk_byte_hold;
    end
  end

  // Store port: the clearing pass owns it until done, then the access logic.
  assign mem_re    = accept;
  assign mem_we    = (state == clk_pram_pkg::ST_CLEAR) || (commit && acc_we);
  assign mem_waddr = (state == clk_pram_pkg::ST_CLEAR) ? clr_addr : addr_hold;
  assign mem_wdata = (state == clk_pram_pkg::ST_CLEAR) ? 8'h00 : acc_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) param_store[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= param_store[in_addr];
  end

  // Track entries 0xe0 and 0xe1 alongside the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      net_0 <= 8'h00;
      net_1 <= 8'h00;
    end else if (commit && acc_we) begin
      if (addr_hold == clk_pram_pkg::ADDR_NET_0) net_0 <= acc_wdata;
      if (addr_hold == clk_pram_pkg::ADDR_NET_1) net_1 <= acc_wdata;
    end
  end

  // Output register: load on commit, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) result_byte <= res;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clk_pram_checker.sv =====
// Checker: port-level assertions for the clock and parameter RAM block, with bind.
`default_nettype none
module clk_pram_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [7:0]  result_byte
);

  // A stalled result holds its byte.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_byte))
    else $error("result changed while stalled");

  // One item at a time: no transfer in the cycle after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input ready right after a transfer");

  // Reset starts the clearing pass, which blocks input, and clears result_valid.
  assert property (@(posedge clk)
    rst |=> !item_ready && !result_valid)
    else $error("block not blocked after reset");

  // Each transfer in brings a result into the output register after its access.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> ##1 result_valid || $past(result_valid && !result_ready))
    else $error("result missing after access");

endmodule

bind clock_pram_register_access clk_pram_checker u_clk_pram_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_byte  (result_byte)
);
`default_nettype wire
